// File: hdl/whp_pkg.sv
// shared constants, codes and types of the weighted state-pair histogram
package whp_pkg;

  // default sizes of the table
  localparam int unsigned MaxStatesDefault     = 64;
  localparam int unsigned NumCategoriesDefault = 4;

  // depth of the command queue between front and back
  localparam int unsigned QueueDepth = 2;

  // field widths
  localparam int unsigned StateW      = 8;
  localparam int unsigned WeightW     = 16;
  localparam int unsigned CountW      = 32;
  localparam int unsigned OpW         = 2;
  localparam int unsigned CatW        = 2;
  localparam int unsigned StateCountW = 7;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CfgDataW    = 8;
  localparam int unsigned InUserW     = OpW + CatW;
  localparam int unsigned InDataW     = 2 * StateW + WeightW;

  // register reset values
  localparam int unsigned          StateCountResetInt = 4;
  localparam logic [StateW-1:0]    UnknownReset       = 8'd255;

  // operation codes of an input word
  typedef enum logic [OpW-1:0] {
    OP_CLEAR     = 2'd0,
    OP_ADD_PAIR  = 2'd1,
    OP_ADD_DIAG  = 2'd2,
    OP_READ      = 2'd3
  } op_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_STATE_COUNT  = 1'b0,
    CFG_UNKNOWN_CODE = 1'b1
  } cfg_idx_e;

  // classified command kinds handed to the back end
  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_SKIP  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e               kind;
    logic [WeightW-1:0] weight;
  } cmd_t;

  // status from back end to front end
  typedef struct packed {
    logic init_busy;
    logic idle;
  } back_status_t;

endpackage

// File: hdl/whp_front.sv
// front end: configuration registers, item classification and table index
module whp_front #(
  parameter int unsigned MAX_STATES     = whp_pkg::MaxStatesDefault,
  parameter int unsigned NUM_CATEGORIES = whp_pkg::NumCategoriesDefault,
  parameter int unsigned IDX_W          = 14
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input words
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  whp_pkg::op_e                  in_op_i,
  input  logic [whp_pkg::StateW-1:0]    in_first_i,
  input  logic [whp_pkg::StateW-1:0]    in_second_i,
  input  logic [whp_pkg::WeightW-1:0]   in_weight_i,
  input  logic [whp_pkg::CatW-1:0]      in_cat_i,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  whp_pkg::cfg_idx_e             cfg_index_i,
  input  logic [whp_pkg::CfgDataW-1:0]  cfg_data_i,
  // back end status
  input  whp_pkg::back_status_t         status_i,
  // towards the command queue
  output logic                          q_valid_o,
  input  logic                          q_ready_i,
  output whp_pkg::cmd_t                 q_cmd_o,
  output logic [IDX_W-1:0]              q_idx_o
);

  localparam int unsigned N_W   = $clog2(MAX_STATES + 1);
  localparam int unsigned SQ_W  = $clog2(MAX_STATES * MAX_STATES + 1);
  localparam int unsigned ROW_W = $clog2(MAX_STATES);
  localparam int unsigned CAT_W = (NUM_CATEGORIES > 1) ? $clog2(NUM_CATEGORIES) : 1;
  localparam int unsigned N_RST = (whp_pkg::StateCountResetInt > MAX_STATES) ?
                                  MAX_STATES : whp_pkg::StateCountResetInt;

  // effective state count, its square and the unknown code
  logic [N_W-1:0]             n_q, n_d;
  logic [SQ_W-1:0]            nsq_q, nsq_d;
  logic [whp_pkg::StateW-1:0] unk_q, unk_d;
  logic [N_W-1:0]             cfg_n;
  logic [SQ_W-1:0]            cfg_n_ext;

  assign cfg_ready_o = 1'b1;

  // clamp the written state count and square it
  always_comb begin
    if (cfg_data_i[whp_pkg::StateCountW-1:0] > MAX_STATES) begin
      cfg_n = N_W'(MAX_STATES);
    end else begin
      cfg_n = N_W'(cfg_data_i[whp_pkg::StateCountW-1:0]);
    end
    cfg_n_ext = SQ_W'(cfg_n);
  end

  always_comb begin
    n_d   = n_q;
    nsq_d = nsq_q;
    unk_d = unk_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        whp_pkg::CFG_STATE_COUNT: begin
          n_d   = cfg_n;
          nsq_d = cfg_n_ext * cfg_n_ext;
        end
        whp_pkg::CFG_UNKNOWN_CODE: begin
          unk_d = cfg_data_i;
        end
        default: begin
          unk_d = unk_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q   <= N_W'(N_RST);
      nsq_q <= SQ_W'(N_RST * N_RST);
      unk_q <= whp_pkg::UnknownReset;
    end else begin
      n_q   <= n_d;
      nsq_q <= nsq_d;
      unk_q <= unk_d;
    end
  end

  // range and unknown checks
  logic                       s1_oor, s2_oor, s1_unk, s2_unk;
  logic [whp_pkg::StateW-1:0] n_state;
  logic [CAT_W-1:0]           cat_eff;
  logic [ROW_W-1:0]           row, col;
  logic [IDX_W-1:0]           row_term, cat_term, idx_c;
  whp_pkg::cmd_t              cmd_c;

  always_comb begin
    n_state = whp_pkg::StateW'(n_q);
    s1_oor  = (in_first_i >= n_state);
    s2_oor  = (in_second_i >= n_state);
    s1_unk  = (in_first_i == unk_q);
    s2_unk  = (in_second_i == unk_q);
    if (32'(in_cat_i) >= NUM_CATEGORIES) begin
      cat_eff = CAT_W'(NUM_CATEGORIES - 1);
    end else begin
      cat_eff = CAT_W'(in_cat_i);
    end
  end

  // linear index: cat*n*n + row*n + col
  always_comb begin
    row = in_first_i[ROW_W-1:0];
    col = (in_op_i == whp_pkg::OP_ADD_DIAG) ? in_first_i[ROW_W-1:0] :
                                               in_second_i[ROW_W-1:0];
    row_term = IDX_W'(row) * IDX_W'(n_q);
    cat_term = IDX_W'(cat_eff) * IDX_W'(nsq_q);
    idx_c    = cat_term + row_term + IDX_W'(col);
  end

  // classify the word
  always_comb begin
    cmd_c.weight = in_weight_i;
    unique case (in_op_i)
      whp_pkg::OP_CLEAR: begin
        cmd_c.kind = whp_pkg::CMD_CLEAR;
      end
      whp_pkg::OP_ADD_PAIR: begin
        cmd_c.kind = (s1_unk || s2_unk || s1_oor || s2_oor) ?
                     whp_pkg::CMD_SKIP : whp_pkg::CMD_ADD;
      end
      whp_pkg::OP_ADD_DIAG: begin
        cmd_c.kind = s1_oor ? whp_pkg::CMD_SKIP : whp_pkg::CMD_ADD;
      end
      whp_pkg::OP_READ: begin
        cmd_c.kind = (s1_oor || s2_oor) ? whp_pkg::CMD_SKIP : whp_pkg::CMD_READ;
      end
      default: begin
        cmd_c.kind = whp_pkg::CMD_SKIP;
      end
    endcase
  end

  // one register stage ahead of the queue
  logic                stg_valid_q, stg_valid_d;
  whp_pkg::cmd_t       stg_cmd_q;
  logic [IDX_W-1:0]    stg_idx_q;
  logic                take;

  assign in_ready_o  = ~status_i.init_busy & (~stg_valid_q | q_ready_i);
  assign take        = in_valid_i & in_ready_o;
  assign stg_valid_d = take | (stg_valid_q & ~q_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      stg_cmd_q <= cmd_c;
      stg_idx_q <= idx_c;
    end
  end

  assign q_valid_o = stg_valid_q;
  assign q_cmd_o   = stg_cmd_q;
  assign q_idx_o   = stg_idx_q;

endmodule

// File: hdl/whp_queue.sv
// short first-in first-out queue of classified commands
module whp_queue #(
  parameter int unsigned W     = 32,
  parameter int unsigned DEPTH = whp_pkg::QueueDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  logic [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output logic [W-1:0] pop_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_data_o   = slot_q[rd_ptr_q];

  // pointer wrap and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: hdl/whp_back.sv
// back end: count table memory, clearing sweep, read-modify-write and result register
module whp_back #(
  parameter int unsigned DEPTH = 16384,
  parameter int unsigned IDX_W = 14
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  output logic                         cmd_ready_o,
  input  whp_pkg::cmd_t                cmd_i,
  input  logic [IDX_W-1:0]             idx_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [whp_pkg::CountW-1:0]   out_count_o,
  output logic                         out_ignored_o,
  output whp_pkg::back_status_t        status_o
);

  localparam logic [2:0] ST_INIT = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_CLR  = 3'd2;
  localparam logic [2:0] ST_DONE = 3'd3;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

  logic [whp_pkg::CountW-1:0]  mem_q [DEPTH];

  logic [2:0]                  state_q, state_d;
  logic [IDX_W-1:0]            addr_q, addr_d;
  whp_pkg::cmd_e               kind_q, kind_d;
  logic [whp_pkg::WeightW-1:0] weight_q, weight_d;
  logic [whp_pkg::CountW-1:0]  rd_data_q;
  logic                        out_valid_q, out_valid_d;
  logic [whp_pkg::CountW-1:0]  out_count_q, out_count_d;
  logic                        out_ign_q, out_ign_d;

  logic                        out_free, load_out, rd_en, mem_we;
  logic [whp_pkg::CountW-1:0]  mem_wdata, sat;
  logic [whp_pkg::CountW:0]    sum;

  assign out_free    = ~out_valid_q | out_ready_i;
  assign cmd_ready_o = (state_q == ST_IDLE);

  // saturating add of the weight
  always_comb begin
    sum = {1'b0, rd_data_q} + (whp_pkg::CountW + 1)'(weight_q);
    sat = sum[whp_pkg::CountW] ? '1 : sum[whp_pkg::CountW-1:0];
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    addr_d    = addr_q;
    kind_d    = kind_q;
    weight_d  = weight_q;
    rd_en     = 1'b0;
    mem_we    = 1'b0;
    mem_wdata = sat;
    load_out  = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        if (addr_q == LAST) begin
          addr_d  = '0;
          state_d = ST_IDLE;
        end else begin
          addr_d  = addr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (cmd_valid_i) begin
          kind_d   = cmd_i.kind;
          weight_d = cmd_i.weight;
          if (cmd_i.kind == whp_pkg::CMD_CLEAR) begin
            addr_d  = '0;
            state_d = ST_CLR;
          end else begin
            addr_d  = idx_i;
            rd_en   = 1'b1;
            state_d = ST_DONE;
          end
        end
      end
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        if (addr_q == LAST) begin
          state_d = ST_DONE;
        end else begin
          addr_d  = addr_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          load_out = 1'b1;
          mem_we   = (kind_q == whp_pkg::CMD_ADD);
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // result value by command kind
  always_comb begin
    unique case (kind_q)
      whp_pkg::CMD_ADD: begin
        out_count_d = sat;
        out_ign_d   = 1'b0;
      end
      whp_pkg::CMD_READ: begin
        out_count_d = rd_data_q;
        out_ign_d   = 1'b0;
      end
      whp_pkg::CMD_SKIP: begin
        out_count_d = '0;
        out_ign_d   = 1'b1;
      end
      default: begin
        out_count_d = '0;
        out_ign_d   = 1'b0;
      end
    endcase
    out_valid_d = load_out | (out_valid_q & ~out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      addr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    weight_q <= weight_d;
    if (load_out) begin
      out_count_q <= out_count_d;
      out_ign_q   <= out_ign_d;
    end
  end

  // table memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[addr_q] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[idx_i];
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_count_o        = out_count_q;
  assign out_ignored_o      = out_ign_q;
  assign status_o.init_busy = (state_q == ST_INIT);
  assign status_o.idle      = (state_q == ST_IDLE) & ~out_valid_q;

endmodule

// File: hdl/weighted_state_pair_histogram_unit.sv
// top level of the weighted state-pair histogram
//
// Input words arrive on s_axis: tuser carries the operation and the rate
// category, tdata the two states and the weight. Each word gives exactly one
// result word on m_axis: tdata is the entry value, tuser the ignored flag.
// Operations: clear all tables, add a weight to a state pair, add a weight
// to a diagonal entry, read an entry. Counts saturate at all ones.
// Configuration (state count, unknown code) is written on the cfg channel,
// which is always ready; write it only while the block is idle.
// A read or add word passes the front register, the queue, the registered
// memory read and the result register, in that order.
// The back end takes no new word before it has finished the last add, read
// or skipped word, because of the read-modify-write on the single table
// memory. A clear walks every table entry, one a cycle:
// NUM_CATEGORIES*MAX_STATES^2 entries (16384 with the defaults).
// After reset the same sweep zeroes the memory; s_axis_tready stays low for
// the whole sweep. A stalled m_axis holds its result while up to four more
// words are taken: one waits in the back end, two in the queue and one in
// the front register.
module weighted_state_pair_histogram_unit #(
  parameter int unsigned MAX_STATES     = whp_pkg::MaxStatesDefault,
  parameter int unsigned NUM_CATEGORIES = whp_pkg::NumCategoriesDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input words
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [whp_pkg::InDataW-1:0]    s_axis_tdata,  // first_state, second_state, weight
  input  logic [whp_pkg::InUserW-1:0]    s_axis_tuser,  // op, category
  // result words
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [whp_pkg::CountW-1:0]     m_axis_tdata,  // count_value
  output logic [0:0]                     m_axis_tuser,  // ignored
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [whp_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [whp_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int unsigned DEPTH = NUM_CATEGORIES * MAX_STATES * MAX_STATES;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CMD_W = $bits(whp_pkg::cmd_t);
  localparam int unsigned Q_W   = CMD_W + IDX_W;

  whp_pkg::back_status_t back_stat;
  logic                  fq_valid, fq_ready, bq_valid, bq_ready;
  whp_pkg::cmd_t         fq_cmd, bq_cmd;
  logic [IDX_W-1:0]      fq_idx, bq_idx;
  logic [Q_W-1:0]        q_pop_data;

  // front end
  whp_front #(
    .MAX_STATES     (MAX_STATES),
    .NUM_CATEGORIES (NUM_CATEGORIES),
    .IDX_W          (IDX_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (whp_pkg::op_e'(s_axis_tuser[whp_pkg::OpW-1:0])),
    .in_first_i  (s_axis_tdata[whp_pkg::StateW-1:0]),
    .in_second_i (s_axis_tdata[2*whp_pkg::StateW-1:whp_pkg::StateW]),
    .in_weight_i (s_axis_tdata[whp_pkg::InDataW-1:2*whp_pkg::StateW]),
    .in_cat_i    (s_axis_tuser[whp_pkg::InUserW-1:whp_pkg::OpW]),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (whp_pkg::cfg_idx_e'(cfg_index_i)),
    .cfg_data_i  (cfg_data_i),
    .status_i    (back_stat),
    .q_valid_o   (fq_valid),
    .q_ready_i   (fq_ready),
    .q_cmd_o     (fq_cmd),
    .q_idx_o     (fq_idx)
  );

  // command queue
  whp_queue #(
    .W     (Q_W),
    .DEPTH (whp_pkg::QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  ({fq_idx, fq_cmd}),
    .pop_valid_o  (bq_valid),
    .pop_ready_i  (bq_ready),
    .pop_data_o   (q_pop_data)
  );

  assign bq_cmd = whp_pkg::cmd_t'(q_pop_data[CMD_W-1:0]);
  assign bq_idx = q_pop_data[Q_W-1:CMD_W];

  // back end
  whp_back #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (bq_valid),
    .cmd_ready_o   (bq_ready),
    .cmd_i         (bq_cmd),
    .idx_i         (bq_idx),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_count_o   (m_axis_tdata),
    .out_ignored_o (m_axis_tuser[0]),
    .status_o      (back_stat)
  );

`ifndef NO_ASSERTIONS
  // no word is taken while the memory is being swept after reset
  a_no_take_in_init : assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.init_busy |-> !s_axis_tready)
    else $error("input word taken during reset sweep");

  // the reset sweep runs once only
  a_init_once : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !back_stat.init_busy |=> !back_stat.init_busy)
    else $error("reset sweep restarted");

  // a skipped word always reports a zero count
  a_skip_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("ignored result carries a nonzero count");

  // the back end only reports idle with nothing pending in its result register
  a_idle_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.idle |-> (!m_axis_tvalid && !back_stat.init_busy))
    else $error("back end idle with a result pending");
`endif

endmodule
